// ===== rtl/core/bsmp_pkg.sv =====
// Shared types, register codes and helpers of the bond-slip material point core.
// No dependencies; every other file of the core imports this package.
package bsmp_pkg;

  localparam int IDX_W      = 10;
  localparam int SLIP_W     = 32;
  localparam int CFG_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_STRESS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESIDUAL_STRESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_SLIP       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RESIDUAL_SLIP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PENALTY         = 3'd4;

  localparam logic [CFG_W-1:0] RST_PEAK_STRESS     = 31'd65536;
  localparam logic [CFG_W-1:0] RST_RESIDUAL_STRESS = 31'd0;
  localparam logic [CFG_W-1:0] RST_PEAK_SLIP       = 31'd65536;
  localparam logic [CFG_W-1:0] RST_RESIDUAL_SLIP   = 31'd131072;
  localparam logic [CFG_W-1:0] RST_PENALTY         = 31'd65536;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_MOD_STEP,
    OP_MEM_RD,
    OP_SLIP,
    OP_MUL_NORM,
    OP_SET_NORM,
    OP_MUL_RISE,
    OP_MUL_SOFT,
    OP_MUL_TOP,
    OP_DIV,
    OP_ENV_RISE,
    OP_ENV_SOFT,
    OP_ENV_RES,
    OP_SLOPE_RISE,
    OP_SLOPE_SOFT,
    OP_STRESS_UNL,
    OP_TAN_UNL,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    NUM_PROD,
    NUM_P_SHIFT,
    NUM_PR_SHIFT,
    NUM_TOP_SHIFT
  } num_sel_t;

  typedef enum logic [1:0] {
    DEN_PS,
    DEN_SOFT,
    DEN_SLIP
  } den_sel_t;

  typedef enum logic [1:0] {
    REG_RISE,
    REG_SOFT,
    REG_RES
  } region_t;

  typedef struct packed {
    dp_op_t   op;
    num_sel_t num_sel;
    den_sel_t den_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic    mod_last;
    logic    clr_last;
    logic    div_done;
    logic    unload;
    region_t region;
  } dp_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] res;
    if (v > 66'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/bond_slip_material_point_core.sv =====
// Top level of the bond-slip material point core: controller plus datapath.
// Uses bsmp_pkg, bsmp_ctrl, bsmp_datapath.
//
//   channel  handshake              payload
//   input    start & !busy          in_point_index, in_tangential_slip,
//                                   in_normal_slip, in_commit_history
//   result   out_valid (1 cycle)    out_shear_stress, out_normal_stress,
//                                   out_tangent_stiffness, out_unloading,
//                                   out_max_slip_used
//   config   cfg_valid & cfg_ready  cfg_index, cfg_data (ready always high)
//
// One item at a time. The quotients an item needs depend on its branch: none when
// loading on the residual plateau, two when loading on the rise or softening branch
// or when unloading from the plateau, and three when unloading from rise or softening.
// Each quotient is started, shifts out its 64 bits and is then taken; the index
// wrap is done by conditional subtraction. busy drops in the out_valid cycle.
// After reset a clearing pass zeroes every history entry; busy stays high
// meanwhile. out_valid pulses for one cycle and cannot be stalled.
module bond_slip_material_point_core
  import bsmp_pkg::*;
#(
  parameter int NUM_POINTS    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [IDX_W-1:0]         in_point_index,
  input  logic signed [SLIP_W-1:0] in_tangential_slip,
  input  logic signed [SLIP_W-1:0] in_normal_slip,
  input  logic                     in_commit_history,
  output logic                     out_valid,
  output logic signed [31:0]       out_shear_stress,
  output logic signed [31:0]       out_normal_stress,
  output logic signed [31:0]       out_tangent_stiffness,
  output logic                     out_unloading,
  output logic [30:0]              out_max_slip_used,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  bsmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  bsmp_datapath #(
    .NUM_POINTS    (NUM_POINTS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg_we                (cfg_valid & cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_point_index        (in_point_index),
    .in_tangential_slip    (in_tangential_slip),
    .in_normal_slip        (in_normal_slip),
    .in_commit_history     (in_commit_history),
    .out_shear_stress      (out_shear_stress),
    .out_normal_stress     (out_normal_stress),
    .out_tangent_stiffness (out_tangent_stiffness),
    .out_unloading         (out_unloading),
    .out_max_slip_used     (out_max_slip_used)
  );

endmodule

// ===== rtl/core/bsmp_divider.sv =====
// Restoring divider, one quotient bit per clock: signed 64-bit dividend by a
// positive 31-bit divisor, quotient truncated toward zero. Uses bsmp_pkg.
module bsmp_divider
  import bsmp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [30:0]        den,
  output logic               done,
  output logic signed [64:0] quo
);

  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] den_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic [31:0] trial;
  logic [63:0] num_mag;

  assign num_mag = num[63] ? (~num + 64'd1) : num;
  assign trial   = {rem_r[30:0], dvd_r[63]};

  always_comb begin
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      dvd_nxt = {dvd_r[62:0], 1'b1};
    end else begin
      rem_nxt = trial;
      dvd_nxt = {dvd_r[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 7'd1);
      if (start) begin
        cnt_r <= 7'd64;
      end else if (cnt_r != 7'd0) begin
        cnt_r <= cnt_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= num_mag;
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[63];
    end else if (cnt_r != 7'd0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});

endmodule

// ===== rtl/core/bsmp_datapath.sv =====
// Datapath: configuration registers, history memory, shared multiplier and
// the divider, driven by commands from bsmp_ctrl. Uses bsmp_pkg, bsmp_divider.
module bsmp_datapath
  import bsmp_pkg::*;
#(
  parameter int NUM_POINTS    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic [IDX_W-1:0]         in_point_index,
  input  logic signed [SLIP_W-1:0] in_tangential_slip,
  input  logic signed [SLIP_W-1:0] in_normal_slip,
  input  logic                     in_commit_history,
  output logic signed [31:0]       out_shear_stress,
  output logic signed [31:0]       out_normal_stress,
  output logic signed [31:0]       out_tangent_stiffness,
  output logic                     out_unloading,
  output logic [30:0]              out_max_slip_used
);

  localparam int AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  logic [CFG_W-1:0] peak_stress_r, residual_stress_r, peak_slip_r, residual_slip_r;
  logic [CFG_W-1:0] penalty_r;
  logic [AW-1:0]    clr_cnt_r;

  logic [IDX_W-1:0]         idx_r;
  logic signed [SLIP_W-1:0] s_r, n_r;
  logic                     commit_r;
  logic [3:0]               mod_cnt_r;
  logic [30:0]              hist_r, slip_r;
  logic                     unload_r, xneg_r;
  logic signed [32:0]       x_r;
  logic [31:0]              magx_r;
  region_t                  region_r;
  logic signed [63:0]       prod_r;
  logic signed [31:0]       normal_r, env_val_r, slope_r, stress_r, tan_r;

  logic [30:0] hist_mem [NUM_POINTS];

  // operand and slip logic
  logic [30:0]        ps_eff, soft_den, mag_c, slip_nxt;
  logic [32:0]        s_ext, mag_s;
  logic               unload_nxt;
  logic [31:0]        magx_nxt;
  region_t            region_nxt;
  logic signed [32:0] p_s, r_s, pr_s, mul_a, mul_b;
  logic signed [65:0] prod_full;
  logic signed [63:0] div_num;
  logic [30:0]        div_den;
  logic               div_done;
  logic signed [64:0] quo;
  logic signed [65:0] q66, v66;
  logic [31:0]        mod_cmp;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [30:0]        mem_wdata;

  assign ps_eff   = (peak_slip_r == '0) ? 31'd1 : peak_slip_r;
  assign soft_den = residual_slip_r - ps_eff;
  assign s_ext    = {s_r[31], s_r};
  assign mag_s    = s_r[31] ? (~s_ext + 33'd1) : s_ext;
  assign mag_c    = (mag_s > 33'h07FFFFFFF) ? 31'h7FFFFFFF : mag_s[30:0];
  assign slip_nxt = (hist_r > mag_c) ? hist_r : mag_c;
  assign unload_nxt = mag_s < {2'b00, slip_nxt};
  assign magx_nxt = unload_nxt ? {1'b0, slip_nxt} : mag_s[31:0];

  always_comb begin
    if (magx_nxt <= {1'b0, ps_eff}) begin
      region_nxt = REG_RISE;
    end else if (magx_nxt <= {1'b0, residual_slip_r}) begin
      region_nxt = REG_SOFT;
    end else begin
      region_nxt = REG_RES;
    end
  end

  assign p_s  = $signed({2'b00, peak_stress_r});
  assign r_s  = $signed({2'b00, residual_stress_r});
  assign pr_s = p_s - r_s;

  always_comb begin
    case (cmd.op)
      OP_MUL_NORM: begin
        mul_a = $signed({2'b00, penalty_r});
        mul_b = $signed({n_r[31], n_r});
      end
      OP_MUL_RISE: begin
        mul_a = p_s;
        mul_b = x_r;
      end
      OP_MUL_SOFT: begin
        mul_a = pr_s;
        mul_b = $signed({1'b0, magx_r - {1'b0, ps_eff}});
      end
      OP_MUL_TOP: begin
        mul_a = $signed({env_val_r[31], env_val_r});
        mul_b = $signed(s_ext);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  always_comb begin
    case (cmd.num_sel)
      NUM_PROD:      div_num = prod_r;
      NUM_P_SHIFT:   div_num = 64'(p_s) <<< FRACTION_BITS;
      NUM_PR_SHIFT:  div_num = 64'(pr_s) <<< FRACTION_BITS;
      NUM_TOP_SHIFT: div_num = 64'(env_val_r) <<< FRACTION_BITS;
      default:       div_num = prod_r;
    endcase
    case (cmd.den_sel)
      DEN_PS:   div_den = ps_eff;
      DEN_SOFT: div_den = soft_den;
      DEN_SLIP: div_den = slip_r;
      default:  div_den = ps_eff;
    endcase
  end

  bsmp_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  assign q66     = 66'(quo);
  assign v66     = 66'(p_s) - q66;
  assign mod_cmp = 32'(NUM_POINTS) << mod_cnt_r;

  // configuration registers and clearing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_stress_r     <= RST_PEAK_STRESS;
      residual_stress_r <= RST_RESIDUAL_STRESS;
      peak_slip_r       <= RST_PEAK_SLIP;
      residual_slip_r   <= RST_RESIDUAL_SLIP;
      penalty_r         <= RST_PENALTY;
      clr_cnt_r         <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PEAK_STRESS:     peak_stress_r     <= cfg_data[CFG_W-1:0];
          CFG_RESIDUAL_STRESS: residual_stress_r <= cfg_data[CFG_W-1:0];
          CFG_PEAK_SLIP:       peak_slip_r       <= cfg_data[CFG_W-1:0];
          CFG_RESIDUAL_SLIP:   residual_slip_r   <= cfg_data[CFG_W-1:0];
          CFG_PENALTY:         penalty_r         <= cfg_data[CFG_W-1:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  // history memory
  assign mem_we    = (cmd.op == OP_CLEAR) || ((cmd.op == OP_OUT) && commit_r);
  assign mem_addr  = (cmd.op == OP_CLEAR) ? clr_cnt_r : AW'(idx_r);
  assign mem_wdata = (cmd.op == OP_CLEAR) ? 31'd0 : slip_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_addr] <= mem_wdata;
    end
    if (cmd.op == OP_MEM_RD) begin
      hist_r <= hist_mem[AW'(idx_r)];
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        idx_r     <= in_point_index;
        s_r       <= in_tangential_slip;
        n_r       <= in_normal_slip;
        commit_r  <= in_commit_history;
        mod_cnt_r <= 4'(IDX_W - 1);
      end
      OP_MOD_STEP: begin
        // reduce the index by NUM_POINTS times a falling power of two where that fits
        if ({22'd0, idx_r} >= mod_cmp) begin
          idx_r <= idx_r - mod_cmp[IDX_W-1:0];
        end
        mod_cnt_r <= mod_cnt_r - 4'd1;
      end
      OP_SLIP: begin
        slip_r   <= slip_nxt;
        unload_r <= unload_nxt;
        magx_r   <= magx_nxt;
        region_r <= region_nxt;
        x_r      <= unload_nxt ? $signed({2'b00, slip_nxt}) : $signed(s_ext);
        xneg_r   <= !unload_nxt && s_r[31];
      end
      OP_MUL_NORM, OP_MUL_RISE, OP_MUL_SOFT, OP_MUL_TOP: begin
        prod_r <= $signed(prod_full[63:0]);
      end
      OP_SET_NORM:   normal_r  <= sat32(66'(prod_r >>> FRACTION_BITS));
      OP_ENV_RISE:   env_val_r <= sat32(q66);
      OP_ENV_SOFT:   env_val_r <= sat32(xneg_r ? -v66 : v66);
      OP_ENV_RES: begin
        env_val_r <= xneg_r ? -$signed({1'b0, residual_stress_r})
                            : $signed({1'b0, residual_stress_r});
        slope_r   <= '0;
      end
      OP_SLOPE_RISE: slope_r  <= sat32(q66);
      OP_SLOPE_SOFT: slope_r  <= sat32(-q66);
      OP_STRESS_UNL: stress_r <= sat32(q66);
      OP_TAN_UNL:    tan_r    <= sat32(q66);
      OP_OUT: begin
        out_shear_stress      <= unload_r ? stress_r : env_val_r;
        out_tangent_stiffness <= unload_r ? tan_r : slope_r;
        out_normal_stress     <= normal_r;
        out_unloading         <= unload_r;
        out_max_slip_used     <= slip_r;
      end
      default: ;
    endcase
  end

  assign sts.mod_last = (mod_cnt_r == 4'd0);
  assign sts.clr_last = (clr_cnt_r == AW'(NUM_POINTS - 1));
  assign sts.div_done = div_done;
  assign sts.unload   = unload_r;
  assign sts.region   = region_r;

endmodule

// ===== rtl/core/bsmp_ctrl.sv =====
// Controller: sequences the clearing pass and the steps of one item through
// the datapath by commands. Uses bsmp_pkg.
module bsmp_ctrl
  import bsmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_SLIP,
    ST_MULN,
    ST_NORM,
    ST_ENV_MUL,
    ST_ENV_RES,
    ST_DIV_V,
    ST_WAIT_V,
    ST_DIV_S,
    ST_WAIT_S,
    ST_UNL_MUL,
    ST_UNL_DIV_S,
    ST_UNL_WAIT_S,
    ST_UNL_DIV_T,
    ST_UNL_WAIT_T,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_nxt;
  logic   rise;

  assign rise = (sts.region == REG_RISE);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd.op        = OP_NONE;
    cmd.num_sel   = NUM_PROD;
    cmd.den_sel   = rise ? DEN_PS : DEN_SOFT;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.op = OP_MOD_STEP;
        if (sts.mod_last) state_nxt = ST_RD;
      end
      ST_RD: begin
        cmd.op    = OP_MEM_RD;
        state_nxt = ST_SLIP;
      end
      ST_SLIP: begin
        cmd.op    = OP_SLIP;
        state_nxt = ST_MULN;
      end
      ST_MULN: begin
        cmd.op    = OP_MUL_NORM;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        cmd.op    = OP_SET_NORM;
        state_nxt = (sts.region == REG_RES) ? ST_ENV_RES : ST_ENV_MUL;
      end
      ST_ENV_RES: begin
        cmd.op    = OP_ENV_RES;
        state_nxt = sts.unload ? ST_UNL_MUL : ST_OUT;
      end
      ST_ENV_MUL: begin
        cmd.op    = rise ? OP_MUL_RISE : OP_MUL_SOFT;
        state_nxt = ST_DIV_V;
      end
      ST_DIV_V: begin
        cmd.op    = OP_DIV;
        state_nxt = ST_WAIT_V;
      end
      ST_WAIT_V: begin
        if (sts.div_done) begin
          cmd.op    = rise ? OP_ENV_RISE : OP_ENV_SOFT;
          state_nxt = sts.unload ? ST_UNL_MUL : ST_DIV_S;
        end
      end
      ST_DIV_S: begin
        cmd.op      = OP_DIV;
        cmd.num_sel = rise ? NUM_P_SHIFT : NUM_PR_SHIFT;
        state_nxt   = ST_WAIT_S;
      end
      ST_WAIT_S: begin
        if (sts.div_done) begin
          cmd.op    = rise ? OP_SLOPE_RISE : OP_SLOPE_SOFT;
          state_nxt = ST_OUT;
        end
      end
      ST_UNL_MUL: begin
        cmd.op    = OP_MUL_TOP;
        state_nxt = ST_UNL_DIV_S;
      end
      ST_UNL_DIV_S: begin
        cmd.op      = OP_DIV;
        cmd.den_sel = DEN_SLIP;
        state_nxt   = ST_UNL_WAIT_S;
      end
      ST_UNL_WAIT_S: begin
        if (sts.div_done) begin
          cmd.op    = OP_STRESS_UNL;
          state_nxt = ST_UNL_DIV_T;
        end
      end
      ST_UNL_DIV_T: begin
        cmd.op      = OP_DIV;
        cmd.num_sel = NUM_TOP_SHIFT;
        cmd.den_sel = DEN_SLIP;
        state_nxt   = ST_UNL_WAIT_T;
      end
      ST_UNL_WAIT_T: begin
        if (sts.div_done) begin
          cmd.op    = OP_TAN_UNL;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd.op        = OP_OUT;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ===== tb/bsmp_checker.sv =====
// Checker for the bond-slip material point core: predicts each result from
// the accepted items and register writes, and compares it field by field.
// Depends on bsmp_pkg for the register indexes and port widths.
module bsmp_checker
  import bsmp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [IDX_W-1:0]         in_point_index,
  input  logic signed [SLIP_W-1:0] in_tangential_slip,
  input  logic signed [SLIP_W-1:0] in_normal_slip,
  input  logic                     in_commit_history,
  input  logic                     out_valid,
  input  logic signed [31:0]       out_shear_stress,
  input  logic signed [31:0]       out_normal_stress,
  input  logic signed [31:0]       out_tangent_stiffness,
  input  logic                     out_unloading,
  input  logic [30:0]              out_max_slip_used,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     NPTS  = 1024;
  localparam int     FRAC  = 16;
  localparam longint ONE_Q = longint'(1) << FRAC;
  localparam longint MAX31 = 64'h7FFF_FFFF;

  typedef struct {
    logic signed [31:0] bond;
    logic signed [31:0] normal;
    logic signed [31:0] tangent;
    logic               unload;
    logic [30:0]        max_slip;
  } bond_result_t;

  logic [30:0] peak_stress, residual_stress, peak_slip, residual_slip, penalty;
  logic [30:0] slip_history [NPTS];
  bond_result_t expected_results [$];

  assign pending = expected_results.size();

  initial begin
    fail_count = 0;
    foreach (slip_history[i]) slip_history[i] = '0;
  end

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Odd envelope: rise, softening, residual plateau; slope returned alongside.
  function automatic longint bond_envelope(input longint x, output longint slope);
    longint p, r, ps, rs, mag, v;
    p   = longint'(peak_stress);
    r   = longint'(residual_stress);
    ps  = (peak_slip == 0) ? 1 : longint'(peak_slip);
    rs  = longint'(residual_slip);
    mag = (x < 0) ? -x : x;
    if (mag <= ps) begin
      slope = clamp32(p * ONE_Q / ps);
      return clamp32(p * x / ps);
    end
    if (mag <= rs) begin
      slope = clamp32(-((p - r) * ONE_Q) / (rs - ps));
      v = p - (p - r) * (mag - ps) / (rs - ps);
    end else begin
      slope = 0;
      v = r;
    end
    return clamp32((x < 0) ? -v : v);
  endfunction

  function automatic bond_result_t predict_bond(input logic [IDX_W-1:0] idx,
                                                input logic signed [31:0] ts,
                                                input logic signed [31:0] ns,
                                                input logic commit);
    bond_result_t res;
    longint s, n, mag, mag_c, hist, slip, top, tan, dummy, stress;
    s     = longint'(ts);
    n     = longint'(ns);
    mag   = (s < 0) ? -s : s;
    mag_c = (mag > MAX31) ? MAX31 : mag;
    hist  = longint'(slip_history[idx % NPTS]);
    slip  = (hist > mag_c) ? hist : mag_c;
    res.unload = mag < slip;
    if (res.unload) begin
      top    = bond_envelope(slip, dummy);
      stress = clamp32(top * s / slip);
      tan    = clamp32(top * ONE_Q / slip);
    end else begin
      stress = bond_envelope(s, tan);
    end
    res.bond     = stress[31:0];
    res.tangent  = tan[31:0];
    // arithmetic shift floors toward minus infinity
    dummy        = clamp32((longint'(penalty) * n) >>> FRAC);
    res.normal   = dummy[31:0];
    res.max_slip = slip[30:0];
    if (commit) slip_history[idx % NPTS] = slip[30:0];
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint exp);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, field, got, exp);
    fail_count++;
  endtask

  always @(posedge clk) begin
    bond_result_t e;
    if (!rst_n) begin
      peak_stress     <= RST_PEAK_STRESS;
      residual_stress <= RST_RESIDUAL_STRESS;
      peak_slip       <= RST_PEAK_SLIP;
      residual_slip   <= RST_RESIDUAL_SLIP;
      penalty         <= RST_PENALTY;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, shear_stress", out_shear_stress, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_shear_stress !== e.bond)
            report_mismatch("shear_stress", out_shear_stress, e.bond);
          if (out_normal_stress !== e.normal)
            report_mismatch("normal_stress", out_normal_stress, e.normal);
          if (out_tangent_stiffness !== e.tangent)
            report_mismatch("tangent_stiffness", out_tangent_stiffness, e.tangent);
          if (out_unloading !== e.unload)
            report_mismatch("unloading", out_unloading, e.unload);
          if (out_max_slip_used !== e.max_slip)
            report_mismatch("max_slip_used", out_max_slip_used, e.max_slip);
        end
      end
      if (start && !busy)
        expected_results.push_back(predict_bond(in_point_index, in_tangential_slip,
                                                in_normal_slip, in_commit_history));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PEAK_STRESS:     peak_stress     <= cfg_data[30:0];
          CFG_RESIDUAL_STRESS: residual_stress <= cfg_data[30:0];
          CFG_PEAK_SLIP:       peak_slip       <= cfg_data[30:0];
          CFG_RESIDUAL_SLIP:   residual_slip   <= cfg_data[30:0];
          CFG_PENALTY:         penalty         <= cfg_data[30:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_bond_slip_material_point_core.sv =====
// Testbench top for the bond-slip material point core: drives items and
// register writes, and gives the verdict. Depends on bsmp_pkg, the core and bsmp_checker.
module tb_bond_slip_material_point_core
  import bsmp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;

  logic clk, rst_n, start, busy, in_commit_history, out_valid, out_unloading;
  logic [IDX_W-1:0] in_point_index;
  logic signed [SLIP_W-1:0] in_tangential_slip, in_normal_slip;
  logic signed [31:0] out_shear_stress, out_normal_stress, out_tangent_stiffness;
  logic [30:0] out_max_slip_used;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending, cycles;
  bit first_item;
  longint cur_peak_slip, cur_res_slip;

  bond_slip_material_point_core u_top (.*);

  bsmp_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("bond_slip_material_point_core: mismatch");
      $finish;
    end
  end

  // Leave start high when the next item follows with no gap.
  task automatic send_item(input logic [IDX_W-1:0] idx, input longint ts,
                           input longint ns, input logic commit);
    int gap;
    gap = first_item ? 1 : $urandom_range(0, 12);
    first_item = 0;
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
    start = 1;
    in_point_index     = idx;
    in_tangential_slip = ts[31:0];
    in_normal_slip     = ns[31:0];
    in_commit_history  = commit;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain_idle();
    if (start) begin
      start = 0;
      first_item = 1;
    end
    while (pending != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_material(input logic [31:0] p, input logic [31:0] r,
                              input logic [31:0] ps, input logic [31:0] rs,
                              input logic [31:0] k);
    drain_idle();
    write_reg(CFG_PEAK_STRESS, p);
    write_reg(CFG_RESIDUAL_STRESS, r);
    write_reg(CFG_PEAK_SLIP, ps);
    write_reg(CFG_RESIDUAL_SLIP, rs);
    write_reg(CFG_PENALTY, k);
    cfg_valid = 0;
    cur_peak_slip = (ps[30:0] == 0) ? 1 : longint'(ps[30:0]);
    cur_res_slip  = longint'(rs[30:0]);
  endtask

  function automatic longint rand_word();
    return longint'($signed($urandom()));
  endfunction

  // Slip magnitude scaled to the envelope corners with a random sign, or one time in ten a random word.
  function automatic longint shaped_slip();
    longint span, m;
    if ($urandom_range(0, 9) == 0) return rand_word();
    span = (cur_res_slip > cur_peak_slip) ? cur_res_slip : cur_peak_slip;
    span = span + span / 2 + 4;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    m = longint'($urandom()) % (span + 1);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic longint normal_value();
    case ($urandom_range(0, 3))
      0:       return rand_word();
      1:       return -longint'($urandom_range(0, 32'h0004_0000));
      default: return longint'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  // Load a point up, then back off and reverse, mostly committing history.
  task automatic slip_cycle(output int count);
    logic [IDX_W-1:0] idx;
    longint peak;
    int n;
    idx  = ($urandom_range(0, 7) == 0) ? IDX_W'($urandom()) : IDX_W'($urandom_range(0, 31));
    peak = shaped_slip();
    n    = $urandom_range(2, 6);
    for (int i = 1; i <= n; i++)
      send_item(idx, peak * i / n, normal_value(), $urandom_range(0, 5) != 0);
    send_item(idx, peak / longint'($urandom_range(2, 5)), normal_value(), 1'b1);
    send_item(idx, -peak / longint'($urandom_range(1, 4)), normal_value(),
              1'($urandom_range(0, 1)));
    count = n + 2;
  endtask

  task automatic random_phase(input int items);
    int sent;
    int cnt;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(IDX_W'($urandom()), rand_word(), rand_word(), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        slip_cycle(cnt);
        sent += cnt;
      end
    end
  endtask

  initial begin
    rst_n = 0; start = 0; first_item = 1;
    in_point_index = '0; in_tangential_slip = '0; in_normal_slip = '0;
    in_commit_history = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    cur_peak_slip = 65536; cur_res_slip = 131072;
    repeat (9) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    drain_idle();

    // zero slip on fresh history, then extremes, envelope corners and unloading
    send_item(IDX_W'(0), 0, 0, 1'b1);
    send_item(IDX_W'(1023), 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 1'b0);
    send_item(IDX_W'(1023), -64'sh8000_0000, -64'sh8000_0000, 1'b1);
    send_item(IDX_W'(1023), -1, -1, 1'b0);
    send_item(IDX_W'(5), 65536, 1, 1'b1);
    send_item(IDX_W'(6), 98304, -65536, 1'b1);
    send_item(IDX_W'(7), 131072, 3, 1'b1);
    send_item(IDX_W'(8), -200000, -3, 1'b1);
    send_item(IDX_W'(6), 32768, 0, 1'b1);
    send_item(IDX_W'(6), -16384, 7, 1'b0);
    send_item(IDX_W'(6), 120000, 0, 1'b1);
    send_item(IDX_W'(7), 0, 0, 1'b0);
    send_item(IDX_W'(9), 40000, 100, 1'b0);
    send_item(IDX_W'(9), 20000, 100, 1'b1);
    send_item(IDX_W'(1023), 64'sh7FFF_FFFF, 0, 1'b1);
    send_item(IDX_W'(1023), 1, 0, 1'b0);
    random_phase(150);

    set_material(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(IDX_W'(1), 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 1'b0);
    send_item(IDX_W'(2), -64'sh8000_0000, -64'sh8000_0000, 1'b0);
    random_phase(150);

    // zero peak slip, empty softening segment, unit registers
    set_material(32'h1, 32'h1, 32'h0, 32'h1, 32'h1);
    send_item(IDX_W'(3), 1, -1, 1'b1);
    send_item(IDX_W'(3), 2, 1, 1'b1);
    random_phase(150);

    // residual above peak stress
    set_material(32'h8000, 32'h2_0000, 32'h1_0000, 32'h4_0000, 32'h3_0000);
    random_phase(150);

    // residual slip below peak slip
    set_material(32'h5_0000, 32'h1_0000, 32'h3_0000, 32'h1_0000, 32'h100);
    random_phase(150);

    // top data bit set, dropped by the 31-bit registers
    set_material(32'h8000_0000 | $urandom_range(1, 32'h20_0000),
                 32'h8000_0000 | $urandom_range(0, 32'h10_0000),
                 32'h8000_0000 | $urandom_range(1, 32'h4_0000),
                 32'h8000_0000 | $urandom_range(32'h4_0000, 32'h10_0000),
                 32'h8000_0000 | $urandom());
    random_phase(150);

    set_material(32'h1_0000, 32'h4000, 32'h1_0000, 32'h2_0000, 32'h1_0000);
    random_phase(150);

    drain_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("bond_slip_material_point_core: match");
    end else begin
      $display("bond_slip_material_point_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/bsmp_pkg.sv
rtl/core/bsmp_divider.sv
rtl/core/bsmp_datapath.sv
rtl/core/bsmp_ctrl.sv
rtl/core/bond_slip_material_point_core.sv
tb/bsmp_checker.sv
tb/tb_bond_slip_material_point_core.sv
